// ===== rtl/lfsr_random_in_range_assert.svh =====
// ----------------------------------------------------------------------------
// lfsr_random_in_range_assert
// Assertion macros shared by the random-in-range block.
// ----------------------------------------------------------------------------
`ifndef LFSR_RANDOM_IN_RANGE_ASSERT_SVH
`define LFSR_RANDOM_IN_RANGE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define LRR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrr assertion failed");
// Next-cycle implication, disabled during reset.
`define LRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrr assertion failed");
`else
`define LRR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LRR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/lrr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_pkg
// Types and constants shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package lrr_pkg;

  localparam int unsigned STATE_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = $clog2(STATE_W);

  localparam logic [STATE_W-1:0] TAP_MASK   = 16'hB400;
  localparam logic [STATE_W-1:0] SEED_VALUE = 16'hACE1;

  typedef struct packed {
    logic start;     // load operands, advance the LFSR, clear the divider
    logic div_step;  // one restoring remainder step
    logic load_out;  // move the finished result into the output register
  } lrr_cmd_t;

  typedef struct packed {
    logic err;       // span is empty or inverted
    logic last;      // current step is the final remainder step
  } lrr_status_t;

endpackage

// ===== rtl/lfsr_random_in_range.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsr_random_in_range
// Galois LFSR random source returning a value in [range_low, range_high).
// ----------------------------------------------------------------------------
// Each request mixes timer_sample into a 16-bit Galois LFSR (seed 0xACE1,
// taps 0xB400), steps it once and returns range_low plus the state modulo
// (range_high - range_low). A request is loaded, then runs sixteen restoring
// remainder steps through the 9-bit trial subtractor (one dividend bit per
// cycle), and then its result is moved into the output register. When
// range_high is not above range_low the division is skipped and range_low
// comes back with range_error set. The output register lets a new request be
// taken while a result waits on rsp_stall.
module lfsr_random_in_range (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [lrr_pkg::BYTE_W-1:0] range_low,
  input  logic [lrr_pkg::BYTE_W-1:0] range_high,
  input  logic [lrr_pkg::BYTE_W-1:0] timer_sample,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic [lrr_pkg::BYTE_W-1:0] random_value,
  output logic                       range_error
);

  lrr_pkg::lrr_cmd_t    cmd;
  lrr_pkg::lrr_status_t status;

  lrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .status    (status)
  );

  lrr_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .range_low    (range_low),
    .range_high   (range_high),
    .timer_sample (timer_sample),
    .random_value (random_value),
    .range_error  (range_error)
  );

endmodule

// ===== rtl/lrr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_datapath
// LFSR state, bit-serial remainder unit and output register.
// ----------------------------------------------------------------------------
`include "lfsr_random_in_range_assert.svh"

module lrr_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  lrr_pkg::lrr_cmd_t               cmd,
  output lrr_pkg::lrr_status_t            status,
  input  logic [lrr_pkg::BYTE_W-1:0]      range_low,
  input  logic [lrr_pkg::BYTE_W-1:0]      range_high,
  input  logic [lrr_pkg::BYTE_W-1:0]      timer_sample,
  output logic [lrr_pkg::BYTE_W-1:0]      random_value,
  output logic                            range_error
);

  logic [lrr_pkg::STATE_W-1:0] lfsr;
  logic [lrr_pkg::STATE_W-1:0] mixed;
  logic [lrr_pkg::STATE_W-1:0] lfsr_next;
  logic [lrr_pkg::STATE_W-1:0] dividend;
  logic [lrr_pkg::BYTE_W-1:0]  rem;
  logic [lrr_pkg::BYTE_W-1:0]  span;
  logic [lrr_pkg::BYTE_W-1:0]  low;
  logic                        err;
  logic [lrr_pkg::CNT_W-1:0]   cnt;
  logic [lrr_pkg::BYTE_W:0]    trial;
  logic [lrr_pkg::BYTE_W:0]    trial_diff;

  // Mix the timer byte into the low byte, then one Galois step.
  always_comb begin
    mixed     = lfsr ^ {{(lrr_pkg::STATE_W - lrr_pkg::BYTE_W){1'b0}}, timer_sample};
    lfsr_next = {1'b0, mixed[lrr_pkg::STATE_W-1:1]};
    if (mixed[0]) begin
      lfsr_next = lfsr_next ^ lrr_pkg::TAP_MASK;
    end
  end

  assign trial      = {rem, dividend[lrr_pkg::STATE_W-1]};
  assign trial_diff = trial - {1'b0, span};

  assign status.err  = err;
  assign status.last = (cnt == {lrr_pkg::CNT_W{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= lrr_pkg::SEED_VALUE;
    end else if (cmd.start) begin
      lfsr <= lfsr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dividend <= lfsr_next;
      low      <= range_low;
      span     <= range_high - range_low;
      err      <= (range_high <= range_low);
      rem      <= '0;
      cnt      <= '0;
    end else if (cmd.div_step) begin
      // Subtract when the shifted remainder reaches the span.
      if (trial >= {1'b0, span}) begin
        rem <= trial_diff[lrr_pkg::BYTE_W-1:0];
      end else begin
        rem <= trial[lrr_pkg::BYTE_W-1:0];
      end
      dividend <= {dividend[lrr_pkg::STATE_W-2:0], 1'b0};
      cnt      <= cnt + 1'b1;
    end
  end

  // On a range error no step ran, so the remainder is still zero.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      random_value <= low + rem;
      range_error  <= err;
    end
  end

  `LRR_ASSERT_IMPL(a_no_step_on_err, clk, rst, cmd.div_step, !err)

endmodule

// ===== rtl/lrr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_ctrl
// Sequencer for request intake, remainder steps and result handoff.
// ----------------------------------------------------------------------------
`include "lfsr_random_in_range_assert.svh"

module lrr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output lrr_pkg::lrr_cmd_t    cmd,
  input  lrr_pkg::lrr_status_t status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.start    = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (status.err) begin
          state_next = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
          if (status.last) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        // Hold the result until the output register can take it.
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `LRR_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.load_out, !rsp_valid || !rsp_stall)
  `LRR_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)
  `LRR_ASSERT_IMPL(a_rsp_from_load, clk, rst, $rose(rsp_valid), $past(cmd.load_out))

endmodule
